/* hw/rtl/tcc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

  // stream payload widths (fields packed from bit 0, padded to bytes)
  localparam int IN_TDATA_W  = 24;  // ch[7:0], cell_addr[20:8]
  localparam int IN_TUSER_W  = 1;   // func[0]
  localparam int OUT_TDATA_W = 24;  // cursor_row[5:0], cursor_col[12:6], cell_data[20:13]

  // field widths
  localparam int CH_W   = 8;
  localparam int ADDR_W = 13;
  localparam int ROW_W  = 6;
  localparam int COL_W  = 7;

  // function codes
  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // character codes
  localparam logic [CH_W-1:0] CH_LF    = 8'd10;
  localparam logic [CH_W-1:0] CH_FF    = 8'd12;
  localparam logic [CH_W-1:0] CH_CR    = 8'd13;
  localparam logic [CH_W-1:0] CH_SPACE = 8'd32;

  // sequencer state codes
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RDWAIT = 2'd1;
  localparam logic [1:0] ST_SCROLL = 2'd2;
  localparam logic [1:0] ST_FILL   = 2'd3;

  typedef logic [CH_W-1:0] byte_t;

endpackage

`default_nettype wire

/* hw/rtl/text_console_cursor_scroll.sv */
`timescale 1ns / 1ps
`default_nettype none

// Character console: a ROWS x COLS byte screen held in one RAM plus a cursor.
// A put item (tuser = 0) stores its byte at the cursor and advances it; bytes 10
// and 13 start a new line, byte 12 clears the screen and homes the cursor. A read
// item (tuser = 1) returns one cell by its linear index. Every item returns one
// result item with the cursor position after it. A read goes through the
// registered RAM read. A new line on the bottom row, by newline byte or wrap,
// scrolls the screen by copying through the single RAM port pair, then blanks
// the last row; a clear sweeps every cell. After reset the block clears
// every cell before it takes the first item. The result of a scroll or clear
// is offered at once; the next item waits for the sweep to finish.

module text_console_cursor_scroll #(
  parameter int COLS = 80,
  parameter int ROWS = 60
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input items
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [tcc_pkg::IN_TDATA_W-1:0]    in_tdata,   // ch[7:0], cell_addr[20:8]
  input  wire logic [tcc_pkg::IN_TUSER_W-1:0]    in_tuser,   // func[0]
  // result items
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [tcc_pkg::OUT_TDATA_W-1:0]   out_tdata   // row[5:0], col[12:6], data[20:13]
);

  import tcc_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CLW   = (COLS > 1) ? $clog2(COLS) : 1;

  localparam logic [AW-1:0]  COLS_A      = AW'(COLS);
  localparam logic [CW-1:0]  CNT_CELLS   = CW'(CELLS);
  localparam logic [CW-1:0]  CNT_LAST    = CW'(CELLS - 1);
  localparam logic [CW-1:0]  CNT_LASTROW = CW'(CELLS - COLS);
  localparam logic [CW-1:0]  CNT_ROW1    = CW'(COLS);
  localparam logic [RW-1:0]  ROW_LAST    = RW'(ROWS - 1);
  localparam logic [CLW:0]   COL_END     = (CLW + 1)'(COLS);

  // control and cursor state
  logic [1:0]      state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            pend_r, pend_nxt;
  logic [AW-1:0]   pend_addr_r, pend_addr_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [CLW-1:0]  col_r, col_nxt;
  logic [AW-1:0]   base_r, base_nxt;
  logic            rd_hit_r, rd_hit_nxt;

  // output register
  logic            out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  byte_t           out_data_r, out_data_nxt;

  // RAM ports
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  byte_t           ram_wdata, ram_rdata;

  // input fields
  logic            in_func;
  byte_t           in_ch;
  logic [ADDR_W-1:0] in_cell_addr;
  logic            in_fire;

  assign in_func      = in_tuser[0];
  assign in_ch        = in_tdata[CH_W-1:0];
  assign in_cell_addr = in_tdata[CH_W+ADDR_W-1:CH_W];

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  // decode of a put item
  logic            is_ff, is_nl, do_nl, at_bottom, rd_in_range;
  logic [CLW:0]    col_inc;

  assign is_ff       = (in_ch == CH_FF);
  assign is_nl       = (in_ch == CH_LF) || (in_ch == CH_CR);
  assign col_inc     = {1'b0, col_r} + 1'b1;
  assign do_nl       = is_nl || (!is_ff && (col_inc == COL_END));
  assign at_bottom   = (row_r == ROW_LAST);
  assign rd_in_range = 32'(in_cell_addr) < 32'(CELLS);

  tcc_ram #(
    .WIDTH(CH_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // sequencer: item handling, scroll copy and fill sweeps
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    base_nxt      = base_r;
    rd_hit_nxt    = rd_hit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = base_r + AW'(col_r);
    ram_wdata     = in_ch;
    ram_re        = 1'b0;
    ram_raddr     = AW'(in_cell_addr);

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_func == FUNC_READ) begin
            ram_re     = rd_in_range;
            rd_hit_nxt = rd_in_range;
            state_nxt  = ST_RDWAIT;
          end else begin
            if (is_ff) begin
              row_nxt   = '0;
              col_nxt   = '0;
              base_nxt  = '0;
              cnt_nxt   = '0;
              state_nxt = ST_FILL;
            end else begin
              // ordinary byte goes to the cursor cell
              ram_we = !is_nl;
              if (do_nl) begin
                col_nxt = '0;
                if (at_bottom) begin
                  cnt_nxt   = CNT_ROW1;
                  state_nxt = ST_SCROLL;
                end else begin
                  row_nxt  = row_r + 1'b1;
                  base_nxt = base_r + COLS_A;
                end
              end else begin
                col_nxt = col_inc[CLW-1:0];
              end
            end
            out_valid_nxt = 1'b1;
            out_row_nxt   = ROW_W'(row_nxt);
            out_col_nxt   = COL_W'(col_nxt);
            out_data_nxt  = '0;
          end
        end
      end

      ST_RDWAIT: begin
        out_valid_nxt = 1'b1;
        out_row_nxt   = ROW_W'(row_r);
        out_col_nxt   = COL_W'(col_r);
        out_data_nxt  = rd_hit_r ? ram_rdata : '0;
        state_nxt     = ST_IDLE;
      end

      ST_SCROLL: begin
        // write back the cell read last cycle one row up
        ram_we    = pend_r;
        ram_waddr = pend_addr_r;
        ram_wdata = ram_rdata;
        if (cnt_r != CNT_CELLS) begin
          ram_re        = 1'b1;
          ram_raddr     = cnt_r[AW-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = cnt_r[AW-1:0] - COLS_A;
          cnt_nxt       = cnt_r + 1'b1;
        end else begin
          cnt_nxt   = CNT_LASTROW;
          state_nxt = ST_FILL;
        end
      end

      ST_FILL: begin
        // blank from cnt to the end of the screen
        ram_we    = 1'b1;
        ram_waddr = cnt_r[AW-1:0];
        ram_wdata = CH_SPACE;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    rd_hit_r    <= rd_hit_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - ROW_W - COL_W - CH_W)'(0),
                       out_data_r, out_col_r, out_row_r};

endmodule

`default_nettype wire

/* hw/rtl/tcc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4800
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* dv/text_console_cursor_scroll_test.sv */
`timescale 1ns / 1ps

module text_console_cursor_scroll_test;
  import tcc_pkg::*;

  localparam int COLS = 80;
  localparam int ROWS = 60;
  localparam int CELLS = ROWS * COLS;
  localparam int RANDOM_ITEMS = 1200;
  // scrolls and clears each sweep the whole screen; cap them to bound run time
  localparam int SWEEP_BUDGET = 100;
  localparam longint CYCLE_LIMIT = 2_000_000;
  localparam int COL_LSB = ROW_W;
  localparam int DATA_LSB = ROW_W + COL_W;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    byte_t            data;
  } cursor_result_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // ch[7:0], cell_addr[20:8]
  logic [IN_TUSER_W-1:0]  in_tuser = '0;   // func[0]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // row[5:0], col[12:6], data[20:13]

  bit     steady_flow;   // both sides run without idling
  int     error_count;
  int     sweep_count;   // scrolls and clears applied by the screen model
  longint cycle_count;

  // screen model and outstanding results
  byte_t          screen_mem [CELLS];
  int             cur_row;
  int             cur_col;
  cursor_result_t expected_q [$];

  text_console_cursor_scroll #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result backpressure
  always @(posedge clk) begin
    if (steady_flow) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 36);
    end
  end

  task automatic report_mismatch(string what, int expected_val, int actual_val);
    $display("cycle %0d: %s mismatch, expected %0d got %0d",
             cycle_count, what, expected_val, actual_val);
    error_count++;
  endtask

  // ---------------- screen model ----------------

  function automatic void clear_screen();
    foreach (screen_mem[i]) screen_mem[i] = CH_SPACE;
    cur_row = 0;
    cur_col = 0;
  endfunction

  function automatic void next_line();
    cur_col = 0;
    cur_row++;
    // past the bottom: shift rows up, blank the last one
    if (cur_row >= ROWS) begin
      for (int i = 0; i < CELLS - COLS; i++) screen_mem[i] = screen_mem[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen_mem[i] = CH_SPACE;
      cur_row = ROWS - 1;
      sweep_count++;
    end
  endfunction

  function automatic cursor_result_t console_apply(logic func, byte_t ch,
                                                   logic [ADDR_W-1:0] addr);
    cursor_result_t res;
    res.data = '0;
    if (func == FUNC_PUT) begin
      if (ch == CH_FF) begin
        clear_screen();
        sweep_count++;
      end else if (ch == CH_LF || ch == CH_CR) begin
        next_line();
      end else begin
        screen_mem[cur_row * COLS + cur_col] = ch;
        cur_col++;
        if (cur_col >= COLS) next_line();
      end
    end else if (addr < CELLS) begin
      res.data = screen_mem[addr];
    end
    res.row = cur_row[ROW_W-1:0];
    res.col = cur_col[COL_W-1:0];
    return res;
  endfunction

  // predict on input handshake, then check any result taken at the same edge
  always @(posedge clk) begin : result_check
    cursor_result_t exp_res;
    if (!rst_n) begin
      clear_screen();
      expected_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        expected_q.push_back(console_apply(in_tuser[0], in_tdata[CH_W-1:0],
                                           in_tdata[CH_W+ADDR_W-1:CH_W]));
      end
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result item", 0, int'(out_tdata));
        end else begin
          exp_res = expected_q.pop_front();
          if (out_tdata[ROW_W-1:0] != exp_res.row)
            report_mismatch("cursor_row", int'(exp_res.row),
                            int'(out_tdata[ROW_W-1:0]));
          if (out_tdata[DATA_LSB-1:COL_LSB] != exp_res.col)
            report_mismatch("cursor_col", int'(exp_res.col),
                            int'(out_tdata[DATA_LSB-1:COL_LSB]));
          if (out_tdata[DATA_LSB+CH_W-1:DATA_LSB] != exp_res.data)
            report_mismatch("cell_data", int'(exp_res.data),
                            int'(out_tdata[DATA_LSB+CH_W-1:DATA_LSB]));
        end
      end
    end
  end

  // ---------------- stimulus helpers ----------------

  task automatic send_item(logic func, byte_t ch, logic [ADDR_W-1:0] addr);
    while (!steady_flow && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= IN_TDATA_W'({addr, ch});
    do @(posedge clk); while (!in_tready);
  endtask

  // address is a don't-care on puts, so keep its bits moving
  task automatic put_char(byte_t ch);
    send_item(FUNC_PUT, ch, ADDR_W'($urandom_range(2**ADDR_W - 1)));
  endtask

  task automatic read_cell(int addr);
    send_item(FUNC_READ, byte_t'($urandom_range(255)), ADDR_W'(addr));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  // any byte that gets stored rather than interpreted
  function automatic byte_t random_glyph();
    byte_t ch;
    do ch = byte_t'($urandom_range(255));
    while (ch == CH_LF || ch == CH_CR || ch == CH_FF);
    return ch;
  endfunction

  function automatic int pick_read_addr();
    int sel;
    sel = $urandom_range(99);
    if (sel < 15) return $urandom_range(2**ADDR_W - 1);
    if (sel < 65) return cur_row * COLS + $urandom_range(COLS - 1);
    return $urandom_range(CELLS - 1);
  endfunction

  // ---------------- tests ----------------

  // field extremes, both functions, newline, clear and out-of-range reads
  task automatic test_directed();
    put_char(8'h41);
    put_char(8'h00);    // control bytes other than 10/12/13 are stored as is
    put_char(8'hFF);
    put_char(8'h07);
    for (int i = 0; i < 5; i++) read_cell(i);
    read_cell(CELLS - 1);
    read_cell(CELLS);           // first index past the screen
    read_cell(2**ADDR_W - 1);
    put_char(CH_LF);
    put_char(8'h42);
    put_char(CH_CR);
    put_char(8'h43);
    read_cell(COLS + 1);
    read_cell(2 * COLS);
    put_char(CH_FF);
    read_cell(0);
    read_cell(2 * COLS);
  endtask

  // a full row wraps to the next one; a newline at column 0 skips a line
  task automatic test_line_wrap();
    put_char(CH_FF);
    repeat (COLS) put_char(random_glyph());
    read_cell(0);
    read_cell(COLS - 1);
    read_cell(COLS);
    put_char(CH_LF);
    put_char(random_glyph());
    repeat (4) read_cell($urandom_range(3 * COLS - 1));
  endtask

  // walk down to the bottom row, then scroll by newline and by wrap
  task automatic test_bottom_scroll();
    put_char(CH_FF);
    for (int r = 0; r < ROWS - 1; r++) begin
      put_char(random_glyph());
      put_char(r[0] ? CH_LF : CH_CR);
    end
    repeat (5) put_char(random_glyph());
    read_cell((ROWS - 1) * COLS);
    put_char(CH_LF);
    read_cell(0);
    read_cell((ROWS - 2) * COLS);
    read_cell((ROWS - 1) * COLS);
    wait_drained();
    repeat (COLS) put_char(random_glyph());
    read_cell((ROWS - 2) * COLS + COLS - 1);
    read_cell(CELLS - 1);
    put_char(CH_CR);
    repeat (4) read_cell((ROWS - 3) * COLS + $urandom_range(3 * COLS - 1));
  endtask

  // mostly text with line breaks, reads around the cursor, rare clears
  task automatic test_random();
    int pick;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady_flow = (n >= 600 && n < 900);
      pick = $urandom_range(999);
      if (sweep_count >= SWEEP_BUDGET || pick < 350) begin
        read_cell(pick_read_addr());
      end else begin
        pick = $urandom_range(999);
        if (pick < 5) begin
          put_char(CH_FF);
        end else if (pick < ((cur_row == ROWS - 1) ? 15 : 105)) begin
          put_char(pick[0] ? CH_LF : CH_CR);
        end else begin
          put_char(random_glyph());
        end
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_line_wrap();
    test_bottom_scroll();
    test_random();
    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/tcc_pkg.sv
hw/rtl/tcc_ram.sv
hw/rtl/text_console_cursor_scroll.sv
dv/text_console_cursor_scroll_test.sv
